FILE: sv/kks_pkg.sv
// ---------------------------------------------------------------------------
// kks_pkg
// Shared constants and helpers for the identifier-keyed key store.
// ---------------------------------------------------------------------------
package kks_pkg;

	// table geometry
	localparam int ENTRY_COUNT_DEF = 16;
	localparam int ID_W = 16;
	localparam int KEY_W = 64;
	localparam int CMD_W = 2;
	localparam int STAT_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SAVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd3;

	// address width for a memory of the given depth, at least one bit
	function automatic int idx_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

FILE: sv/id_keyed_key_store.sv
// ---------------------------------------------------------------------------
// id_keyed_key_store
// Table of identifier / 128-bit key pairs with query, save and clear.
// ---------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. Each command
//   gives exactly one result beat: done is high for one cycle with status,
//   key_high_out and key_low_out; the receiver cannot stall, so the result
//   must be taken in that cycle.
//   Clear, the unused command and the reserved identifier 0 finish at once:
//   done follows in the cycle after the beat and busy stays low.
//   Query and save scan the identifier memory one entry a cycle, so busy
//   stays high through the scan, the commit step and, for a query that
//   hits, a read of the key memory; done is high in the same cycle that
//   busy goes low. The scan through the single read port of the identifier
//   memory sets how long busy stays high.
//   Occupancy lives in one valid bit per entry, so clear and reset empty
//   the table at once; the memories themselves are not reset.
// ---------------------------------------------------------------------------
module id_keyed_key_store import kks_pkg::*; #(
	parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  command,
	input  logic [ID_W-1:0]   door_id,
	input  logic [KEY_W-1:0]  key_high_in,
	input  logic [KEY_W-1:0]  key_low_in,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [KEY_W-1:0]  key_high_out,
	output logic [KEY_W-1:0]  key_low_out
);

	localparam int IW = idx_w(ENTRY_COUNT);
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRY_COUNT - 1);

	// state codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_ACT = 2'd2;
	localparam logic [1:0] S_KEY = 2'd3;

	logic [1:0]             state_q;
	logic [ENTRY_COUNT-1:0] valid_q;

	// latched command beat
	logic [CMD_W-1:0]   cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [2*KEY_W-1:0] key_q;

	// scan control
	logic [IW-1:0] scan_addr_q;
	logic          issue_done_q;
	logic          rd_vld_s1;
	logic          rd_last_s1;
	logic [IW-1:0] rd_idx_s1;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          emp_q;
	logic [IW-1:0] emp_idx_q;

	// result registers
	logic               done_q;
	logic [STAT_W-1:0]  status_q;
	logic [KEY_W-1:0]   key_high_q;
	logic [KEY_W-1:0]   key_low_q;

	// memory ports
	logic               id_re;
	logic               id_we;
	logic [IW-1:0]      tgt_idx;
	logic [ID_W-1:0]    id_rdata;
	logic               key_re;
	logic [2*KEY_W-1:0] key_rdata;

	logic accept;
	logic slot_match;
	logic slot_empty;
	logic save_ok;

	assign accept = start && (state_q == S_IDLE);

	// scan compares: an entry without its valid bit reads as empty
	assign slot_match = valid_q[rd_idx_s1] && (id_rdata == id_q);
	assign slot_empty = !valid_q[rd_idx_s1];

	// commit decisions
	assign tgt_idx = hit_q ? hit_idx_q : emp_idx_q;
	assign save_ok = hit_q || emp_q;
	assign id_re = (state_q == S_SCAN) && !issue_done_q;
	assign id_we = (state_q == S_ACT) && (cmd_q == CMD_SAVE) && save_ok;
	assign key_re = (state_q == S_ACT) && (cmd_q == CMD_QUERY) && hit_q;

	kks_ram #(
		.WIDTH (ID_W),
		.DEPTH (ENTRY_COUNT)
	) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (tgt_idx),
		.wdata (id_q),
		.re    (id_re),
		.raddr (scan_addr_q),
		.rdata (id_rdata)
	);

	kks_ram #(
		.WIDTH (2*KEY_W),
		.DEPTH (ENTRY_COUNT)
	) u_key_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (tgt_idx),
		.wdata (key_q),
		.re    (key_re),
		.raddr (hit_idx_q),
		.rdata (key_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			emp_q        <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= id_re;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						hit_q        <= 1'b0;
						emp_q        <= 1'b0;
						issue_done_q <= 1'b0;
						if (command == CMD_CLEAR) begin
							valid_q <= '0;
						end
						if ((command == CMD_QUERY || command == CMD_SAVE) &&
						    door_id != '0) begin
							state_q <= S_SCAN;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (id_re && scan_addr_q == LAST_IDX) begin
						issue_done_q <= 1'b1;
					end
					if (rd_vld_s1) begin
						if (!hit_q && slot_match) begin
							hit_q <= 1'b1;
						end
						if (!emp_q && slot_empty) begin
							emp_q <= 1'b1;
						end
						if (rd_last_s1) begin
							state_q <= S_ACT;
						end
					end
				end
				S_ACT: begin
					if (key_re) begin
						state_q <= S_KEY;
					end else begin
						if (id_we) begin
							valid_q[tgt_idx] <= 1'b1;
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_KEY: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command beat, scan indexes and read pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= command;
			id_q        <= door_id;
			key_q       <= {key_high_in, key_low_in};
			scan_addr_q <= '0;
		end else if (id_re) begin
			scan_addr_q <= scan_addr_q + IW'(1);
		end
		rd_idx_s1  <= scan_addr_q;
		rd_last_s1 <= (scan_addr_q == LAST_IDX);
		if (state_q == S_SCAN && rd_vld_s1) begin
			if (!hit_q && slot_match) begin
				hit_idx_q <= rd_idx_s1;
			end
			if (!emp_q && slot_empty) begin
				emp_idx_q <= rd_idx_s1;
			end
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q   <= ((command == CMD_QUERY || command == CMD_SAVE) && door_id == '0)
				? ST_INVALID : ST_OK;
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (state_q == S_ACT) begin
			if (cmd_q == CMD_QUERY) begin
				status_q <= hit_q ? ST_OK : ST_NOT_FOUND;
			end else begin
				status_q <= save_ok ? ST_OK : ST_FULL;
			end
		end else if (state_q == S_KEY) begin
			key_high_q <= key_rdata[2*KEY_W-1:KEY_W];
			key_low_q  <= key_rdata[KEY_W-1:0];
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign key_high_out = key_high_q;
	assign key_low_out = key_low_q;

	// an accepted beat either finishes next cycle or starts a scan
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("accepted beat neither finished nor started a scan");

	// commit only follows the last scan read
	a_act_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACT) |-> $past(rd_vld_s1 && rd_last_s1))
		else $error("commit without a finished scan");

	// only a successful result carries key bits
	a_key_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK) || (key_high_out == '0 && key_low_out == '0))
		else $error("key bits on a failed result");

	// clear empties every slot
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_CLEAR) |=> (valid_q == '0))
		else $error("valid bits left after clear");

endmodule

FILE: sv/kks_ram.sv
// ---------------------------------------------------------------------------
// kks_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module kks_ram import kks_pkg::*; #(
	parameter int WIDTH = 16,
	parameter int DEPTH = ENTRY_COUNT_DEF
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [idx_w(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic                      re,
	input  logic [idx_w(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: tb/sv/id_keyed_key_store_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// id_keyed_key_store_tb
// Self-checking bench for the identifier-keyed key store: directed cases for
// reserved identifiers, lookups, overwrites, a full table and clear, then
// random command traffic over identifier pools of several sizes. Every result
// beat is checked against a local model of the table.
// ---------------------------------------------------------------------------
module id_keyed_key_store_tb;
	import kks_pkg::*;

	localparam int SLOTS = ENTRY_COUNT_DEF;

	typedef struct {
		logic [STAT_W-1:0] st;
		logic [KEY_W-1:0]  hi;
		logic [KEY_W-1:0]  lo;
	} key_reply_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CMD_W-1:0]  command;
	logic [ID_W-1:0]   door_id;
	logic [KEY_W-1:0]  key_high_in;
	logic [KEY_W-1:0]  key_low_in;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [KEY_W-1:0]  key_high_out;
	logic [KEY_W-1:0]  key_low_out;

	// model of the table contents
	logic [ID_W-1:0]  tbl_id [SLOTS];
	logic [KEY_W-1:0] tbl_key_hi [SLOTS];
	logic [KEY_W-1:0] tbl_key_lo [SLOTS];

	key_reply_t key_reply_q[$];
	key_reply_t seen_exp;
	int fail_cnt = 0;

	id_keyed_key_store #(.ENTRY_COUNT(SLOTS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.door_id      (door_id),
		.key_high_in  (key_high_in),
		.key_low_in   (key_low_in),
		.done         (done),
		.status       (status),
		.key_high_out (key_high_out),
		.key_low_out  (key_low_out)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// first slot holding an identifier, -1 if none
	function automatic int slot_of(input logic [ID_W-1:0] id);
		int hit;
		hit = -1;
		for (int i = 0; i < SLOTS; i++)
			if (hit < 0 && tbl_id[i] == id)
				hit = i;
		return hit;
	endfunction

	// apply one command to the table model and return the reply it gives
	function automatic key_reply_t key_table_apply(input logic [CMD_W-1:0] cmd,
			input logic [ID_W-1:0] id, input logic [KEY_W-1:0] hi,
			input logic [KEY_W-1:0] lo);
		key_reply_t r;
		int slot;
		r.st = ST_OK;
		r.hi = '0;
		r.lo = '0;
		case (cmd)
			CMD_CLEAR: begin
				for (int i = 0; i < SLOTS; i++)
					tbl_id[i] = '0;
			end
			CMD_QUERY: begin
				slot = slot_of(id);
				if (id == '0)
					r.st = ST_INVALID;
				else if (slot < 0)
					r.st = ST_NOT_FOUND;
				else begin
					r.hi = tbl_key_hi[slot];
					r.lo = tbl_key_lo[slot];
				end
			end
			CMD_SAVE: begin
				slot = slot_of(id);
				if (slot < 0)
					slot = slot_of('0);
				if (id == '0)
					r.st = ST_INVALID;
				else if (slot < 0)
					r.st = ST_FULL;
				else begin
					tbl_id[slot] = id;
					tbl_key_hi[slot] = hi;
					tbl_key_lo[slot] = lo;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// check each result beat against the oldest expected reply
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (key_reply_q.size() == 0) begin
				$error("result beat with no command outstanding");
				fail_cnt++;
			end else begin
				seen_exp = key_reply_q.pop_front();
				if (status !== seen_exp.st) begin
					$error("status: expected %0d, actual %0d", seen_exp.st, status);
					fail_cnt++;
				end
				if (key_high_out !== seen_exp.hi) begin
					$error("key_high_out: expected %h, actual %h", seen_exp.hi, key_high_out);
					fail_cnt++;
				end
				if (key_low_out !== seen_exp.lo) begin
					$error("key_low_out: expected %h, actual %h", seen_exp.lo, key_low_out);
					fail_cnt++;
				end
			end
		end
	end

	// send one command beat, then idle for a random gap
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
			input logic [KEY_W-1:0] hi, input logic [KEY_W-1:0] lo);
		int gap;
		int r;
		start <= 1'b1;
		command <= cmd;
		door_id <= id;
		key_high_in <= hi;
		key_low_in <= lo;
		do @(posedge clk); while (busy);
		key_reply_q.push_back(key_table_apply(cmd, id, hi, lo));
		// mostly back to back or short gaps, a few long ones
		r = $urandom_range(0, 99);
		if (r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every expected reply has arrived
	task automatic drain_replies();
		int n;
		n = 0;
		start <= 1'b0;
		while (key_reply_q.size() != 0 && n < 500) begin
			@(posedge clk);
			n++;
		end
		if (key_reply_q.size() != 0) begin
			$error("%0d result beats never arrived", key_reply_q.size());
			fail_cnt++;
			key_reply_q.delete();
		end
	endtask

	// reserved identifier, unused command and lookup in an empty table
	task automatic test_reserved_and_unused();
		send_beat(CMD_QUERY, '0, '0, '0);
		send_beat(CMD_SAVE, '0, '1, '1);
		send_beat(CMD_NONE, 16'hffff, '1, '1);
		send_beat(CMD_QUERY, 16'h0001, '0, '0);
		drain_replies();
	endtask

	// save at the identifier extremes and read back
	task automatic test_save_and_lookup();
		send_beat(CMD_SAVE, 16'h0001, '1, '1);
		send_beat(CMD_SAVE, 16'hffff, '0, '0);
		send_beat(CMD_QUERY, 16'h0001, '0, '0);
		send_beat(CMD_QUERY, 16'hffff, '1, '1);
		drain_replies();
	endtask

	// fill every slot, then a new identifier is refused but an overwrite works
	task automatic test_table_full();
		for (int i = 0; i < SLOTS - 2; i++)
			send_beat(CMD_SAVE, ID_W'(16'h0100 + i), {$urandom, $urandom},
				{$urandom, $urandom});
		send_beat(CMD_SAVE, 16'h7777, {$urandom, $urandom}, {$urandom, $urandom});
		send_beat(CMD_SAVE, 16'h0001, 64'ha5a5_5a5a_0f0f_f0f0, 64'h0123_4567_89ab_cdef);
		send_beat(CMD_QUERY, 16'h0001, '0, '0);
		drain_replies();
	endtask

	// clear ignores its operands and empties the table
	task automatic test_clear();
		send_beat(CMD_CLEAR, 16'h1234, '1, '1);
		send_beat(CMD_QUERY, 16'hffff, '0, '0);
		drain_replies();
	endtask

	// random commands over a pool of identifiers; pool size sets how often the
	// table fills up
	task automatic test_random_traffic(input int pool_n, input int count);
		logic [ID_W-1:0]  pool[$];
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] hi;
		logic [KEY_W-1:0] lo;
		int r;
		pool.push_back(16'h0001);
		pool.push_back(16'hffff);
		while (pool.size() < pool_n)
			pool.push_back(ID_W'($urandom_range(1, 16'hffff)));
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 999);
			if (r < 12)
				cmd = CMD_CLEAR;
			else if (r < 30)
				cmd = CMD_NONE;
			else if (r < 510)
				cmd = CMD_SAVE;
			else
				cmd = CMD_QUERY;
			r = $urandom_range(0, 99);
			if (r < 75)
				id = pool[$urandom_range(0, pool.size() - 1)];
			else if (r < 95)
				id = ID_W'($urandom);
			else
				id = '0;
			case ($urandom_range(0, 9))
				0: hi = '1;
				1: hi = '0;
				default: hi = {$urandom, $urandom};
			endcase
			case ($urandom_range(0, 9))
				0: lo = '1;
				1: lo = '0;
				default: lo = {$urandom, $urandom};
			endcase
			send_beat(cmd, id, hi, lo);
		end
		drain_replies();
	endtask

	// run limit
	initial begin
		#4ms;
		$display("Regression FAIL");
		$finish;
	end

	// main sequence
	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_id[i] = '0;
			tbl_key_hi[i] = '0;
			tbl_key_lo[i] = '0;
		end
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_QUERY;
		door_id = '0;
		key_high_in = '0;
		key_low_in = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reserved_and_unused();
		test_save_and_lookup();
		test_table_full();
		test_clear();
		test_random_traffic(8, 400);
		test_random_traffic(20, 500);
		test_random_traffic(40, 400);
		test_random_traffic(24, 300);

		// let any stray result beat show up
		repeat (40) @(posedge clk);
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
sv/kks_pkg.sv
sv/kks_ram.sv
sv/id_keyed_key_store.sv
tb/sv/id_keyed_key_store_tb.sv
